FILE: sv/governor_valve_limiter_events_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the governor valve limiter
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GOVERNOR_VALVE_LIMITER_EVENTS_ASSERT_SVH
`define GOVERNOR_VALVE_LIMITER_EVENTS_ASSERT_SVH

// condition holds at every edge
`define GVL_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define GVL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gvl_pkg.sv
// ----------------------------------------------------------------------------
// gvl_pkg
// Types, microcode and fixed-point helpers of the governor valve limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gvl_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int STEP_W        = 3;

  // configuration register indexes
  localparam logic [2:0] CFG_LEAD_GAIN  = 3'd0;
  localparam logic [2:0] CFG_INV_RATE   = 3'd1;
  localparam logic [2:0] CFG_POWER_REF  = 3'd2;
  localparam logic [2:0] CFG_RATE_OPEN  = 3'd3;
  localparam logic [2:0] CFG_RATE_CLOSE = 3'd4;
  localparam logic [2:0] CFG_POS_MAX    = 3'd5;
  localparam logic [2:0] CFG_POS_MIN    = 3'd6;

  // action codes
  localparam logic [1:0] ACT_EVAL    = 2'd0;
  localparam logic [1:0] ACT_RESOLVE = 2'd1;
  localparam logic [1:0] ACT_TRIGGER = 2'd2;

  // flag bit positions
  localparam int FL_RATE_MIN = 0;
  localparam int FL_RATE_MAX = 1;
  localparam int FL_POS_MIN  = 2;
  localparam int FL_POS_MAX  = 3;

  typedef enum logic [2:0] {
    OP_CLR,
    OP_MUL_LL,
    OP_SCALE,
    OP_ADD_LL,
    OP_DIFF,
    OP_MUL_RATE,
    OP_FINISH
  } op_e;

  typedef enum logic {
    COND_NONE,
    COND_GAIN_ZERO
  } cond_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } ucode_t;

  typedef struct packed {
    logic act;
    op_e  op;
  } ctrl_t;

  typedef struct packed {
    logic stall;
    logic gain_zero;
  } seq_stat_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      3'd0: w = '{OP_CLR,      COND_GAIN_ZERO, 3'd3, 1'b0};
      3'd1: w = '{OP_MUL_LL,   COND_NONE,      3'd0, 1'b0};
      3'd2: w = '{OP_SCALE,    COND_NONE,      3'd0, 1'b0};
      3'd3: w = '{OP_ADD_LL,   COND_NONE,      3'd0, 1'b0};
      3'd4: w = '{OP_DIFF,     COND_NONE,      3'd0, 1'b0};
      3'd5: w = '{OP_MUL_RATE, COND_NONE,      3'd0, 1'b0};
      3'd6: w = '{OP_SCALE,    COND_NONE,      3'd0, 1'b0};
      3'd7: w = '{OP_FINISH,   COND_NONE,      3'd0, 1'b1};
    endcase
    return w;
  endfunction

  function automatic logic [63:0] sx64(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] v);
    if (v[63:31] == '0 || v[63:31] == '1) begin
      return v[31:0];
    end else if (v[63]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

endpackage

`default_nettype wire

FILE: sv/gvl_seq.sv
// ----------------------------------------------------------------------------
// gvl_seq
// Microcode sequencer: step counter over the control store, with a skip
// jump and a hold on the final step while the result register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gvl_seq
  import gvl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  seq_stat_t stat_i,
  output ctrl_t     ctrl_o,
  output logic      busy_o
);

  seq_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            word;

  assign word = ucode_rom(step_q);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (start_i) begin
          state_d = SEQ_RUN;
          step_d  = '0;
        end
      end
      SEQ_RUN: begin
        if (word.last) begin
          if (!stat_i.stall) begin
            state_d = SEQ_IDLE;
          end
        end else if (word.cond == COND_GAIN_ZERO && stat_i.gain_zero) begin
          step_d = word.target;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    busy_o     = (state_q == SEQ_RUN);
    ctrl_o.act = (state_q == SEQ_RUN);
    ctrl_o.op  = word.op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/governor_valve_limiter_events.sv
// ----------------------------------------------------------------------------
// governor_valve_limiter_events
// Governor valve limiter: lead-lag output, valve rate, limit event values
// and hold flag handling in Q16.16 with saturation.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  s_axis    in         s_axis_tvalid/tready       tdata: ll, pos, dw, trig; tuser: action
//  m_axis    out        m_axis_tvalid/tready       tdata: rate, 4 events, flags
//  cfg       in         cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
//  An item runs through eight microcode steps, two of them on the shared 32x32
//  multiplier, each product followed by a shift and saturate step; when lead_gain is
//  zero the jump skips the first product and its shift step. The sequencer then
//  returns to idle, and no new item is accepted until it does.
//  The result sits in an output register; the final step holds while it is full and unread.
//  Reset clears configuration, flags and handshake state. cfg is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module governor_valve_limiter_events
  import gvl_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] ll_state, [63:32] gv_position, [95:64] speed_dev,
  // [99:96] trigger_bits, [103:100] zero
  input  logic [103:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] valve_rate, [63:32] ev_rate_low, [95:64] ev_rate_high,
  // [127:96] ev_pos_low, [159:128] ev_pos_high, [163:160] limit_flags,
  // [167:164] zero
  output logic [167:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  logic [31:0] lead_gain_q, inv_rate_q, power_ref_q, rate_open_q;
  logic [31:0] rate_close_q, pos_max_q, pos_min_q;

  logic [1:0]  act_q;
  logic [31:0] xll_q, xgv_q, dw_q;
  logic [3:0]  trig_q;

  logic [31:0] r_q, r_d;
  logic [63:0] p_q, p_d;
  logic [31:0] mul_a, mul_b;

  logic [3:0]  flags_q, flags_d;
  logic [31:0] ev0, ev1, ev2, ev3;

  logic         out_valid_q;
  logic [167:0] out_data_q;

  logic      in_acc, out_load, busy;
  ctrl_t     ctrl;
  seq_stat_t stat;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign out_load   = ctrl.act && ctrl.op == OP_FINISH && (!out_valid_q || m_axis_tready);
  assign stat.stall = out_valid_q && !m_axis_tready;
  assign stat.gain_zero = (lead_gain_q == '0);

  gvl_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_gain_q  <= '0;
      inv_rate_q   <= '0;
      power_ref_q  <= '0;
      rate_open_q  <= '0;
      rate_close_q <= '0;
      pos_max_q    <= '0;
      pos_min_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LEAD_GAIN:  lead_gain_q  <= cfg_data_i;
        CFG_INV_RATE:   inv_rate_q   <= cfg_data_i;
        CFG_POWER_REF:  power_ref_q  <= cfg_data_i;
        CFG_RATE_OPEN:  rate_open_q  <= cfg_data_i;
        CFG_RATE_CLOSE: rate_close_q <= cfg_data_i;
        CFG_POS_MAX:    pos_max_q    <= cfg_data_i;
        CFG_POS_MIN:    pos_min_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= s_axis_tuser;
      xll_q  <= s_axis_tdata[31:0];
      xgv_q  <= s_axis_tdata[63:32];
      dw_q   <= s_axis_tdata[95:64];
      trig_q <= s_axis_tdata[99:96];
    end
  end

  // shared multiplier operands
  always_comb begin
    if (ctrl.op == OP_MUL_RATE) begin
      mul_a = r_q;
      mul_b = inv_rate_q;
    end else begin
      mul_a = lead_gain_q;
      mul_b = dw_q;
    end
  end

  always_comb begin
    r_d = r_q;
    p_d = p_q;
    if (ctrl.act) begin
      unique case (ctrl.op)
        OP_CLR:                 r_d = '0;
        OP_MUL_LL, OP_MUL_RATE: p_d = 64'($signed(mul_a) * $signed(mul_b));
        OP_SCALE:               r_d = sat32(64'($signed(p_q) >>> FRAC_BITS));
        OP_ADD_LL:              r_d = sat32(sx64(xll_q) + sx64(r_q));
        OP_DIFF:                r_d = sat32(sx64(power_ref_q) - sx64(xgv_q) - sx64(r_q));
        OP_FINISH:              ;
        default:                ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    p_q <= p_d;
  end

  // r_q holds the valve rate at the finish step
  always_comb begin
    ev0 = '0;
    ev1 = '0;
    ev2 = '0;
    ev3 = '0;
    if (act_q == ACT_EVAL) begin
      ev0 = flags_q[FL_RATE_MIN] ? sat32(sx64(rate_close_q) - sx64(r_q))
                                 : sat32(sx64(r_q) - sx64(rate_close_q));
      ev1 = flags_q[FL_RATE_MAX] ? sat32(sx64(r_q) - sx64(rate_open_q))
                                 : sat32(sx64(rate_open_q) - sx64(r_q));
      ev2 = flags_q[FL_POS_MIN]  ? sat32(64'd0 - sx64(r_q))
                                 : sat32(sx64(xgv_q) - sx64(pos_min_q));
      ev3 = flags_q[FL_POS_MAX]  ? r_q
                                 : sat32(sx64(pos_max_q) - sx64(xgv_q));
    end
  end

  always_comb begin
    flags_d = flags_q;
    unique case (act_q)
      ACT_RESOLVE: begin
        if (!flags_q[FL_RATE_MIN]) begin
          flags_d[FL_RATE_MIN] = $signed(r_q) < $signed(rate_close_q);
        end else begin
          flags_d[FL_RATE_MIN] = !($signed(r_q) > $signed(rate_open_q));
        end
        if (!flags_q[FL_RATE_MAX]) begin
          flags_d[FL_RATE_MAX] = $signed(r_q) > $signed(rate_open_q);
        end else begin
          flags_d[FL_RATE_MAX] = !($signed(r_q) < $signed(rate_open_q));
        end
        if (!flags_q[FL_POS_MIN]) begin
          flags_d[FL_POS_MIN] = $signed(xgv_q) < $signed(pos_min_q);
        end else begin
          flags_d[FL_POS_MIN] = !($signed(r_q) > 32'sd0);
        end
        if (!flags_q[FL_POS_MAX]) begin
          flags_d[FL_POS_MAX] = $signed(xgv_q) > $signed(pos_max_q);
        end else begin
          flags_d[FL_POS_MAX] = !r_q[31];
        end
      end
      ACT_TRIGGER: begin
        if (trig_q[FL_RATE_MIN]) flags_d[FL_RATE_MIN] = !flags_q[FL_RATE_MIN];
        if (trig_q[FL_RATE_MAX]) flags_d[FL_RATE_MAX] = !flags_q[FL_RATE_MAX];
        if (trig_q[FL_POS_MIN]) flags_d[FL_POS_MIN] = !flags_q[FL_POS_MIN] && r_q[31];
        if (trig_q[FL_POS_MAX]) begin
          flags_d[FL_POS_MAX] = !flags_q[FL_POS_MAX] && $signed(r_q) > 32'sd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        flags_q     <= flags_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {4'd0, flags_d, ev3, ev2, ev1, ev0, r_q};
    end
  end

`include "governor_valve_limiter_events_assert.svh"

  `GVL_ASSERT_NEXT(a_accept_starts_run, in_acc, busy, "accepted item did not start the program")
  `GVL_ASSERT_NEXT(a_flags_only_on_load, !out_load, $stable(flags_q), "flags moved without a result")
  `GVL_ASSERT_NEXT(a_load_gives_valid, out_load, m_axis_tvalid && !busy, "result load lost")

endmodule

`default_nettype wire

FILE: tb/tb_governor_valve_limiter_events.sv
// ----------------------------------------------------------------------------
// tb_governor_valve_limiter_events
// Self-checking testbench for the governor valve limiter. Items go in on the
// input stream. A scoreboard class recomputes the lead-lag output, the valve
// rate, the event values and the hold flags for every accepted item and
// checks each result transaction against the oldest prediction. The run
// covers reset and directed register settings, all-max, all-min, zero-servo
// and random settings, and random stalls on both sides. It includes one long
// receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_governor_valve_limiter_events;
  import gvl_pkg::*;

  localparam int     FRAC        = FRAC_BITS_DEF;
  localparam int     ONE         = 1 << FRAC;
  localparam int     DRAIN       = 24;
  localparam int     QUIET_LIMIT = 5000;
  localparam int     PHASE_ITEMS = 200;
  localparam int     HOLD_AT     = 400;
  localparam int     HOLD_LEN    = 300;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef enum {
    SET_TYPICAL, SET_ALGEBRAIC, SET_ALL_MAX, SET_ALL_MIN, SET_NO_SERVO, SET_WIDE
  } setting_kind_e;

  localparam setting_kind_e PHASE_PLAN [8] = '{
    SET_TYPICAL, SET_ALGEBRAIC, SET_ALL_MAX, SET_TYPICAL,
    SET_ALL_MIN, SET_NO_SERVO, SET_WIDE, SET_TYPICAL
  };

  typedef struct packed {
    logic [31:0] lead_gain;
    logic [31:0] inv_rate;
    logic [31:0] power_ref;
    logic [31:0] rate_open;
    logic [31:0] rate_close;
    logic [31:0] pos_max;
    logic [31:0] pos_min;
  } limiter_cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] ll_state;
    logic [31:0] gv_position;
    logic [31:0] speed_dev;
    logic [3:0]  trigger_bits;
  } valve_item_t;

  // packed so that valve_rate lands in the lowest bits
  typedef struct packed {
    logic [3:0]  limit_flags;
    logic [31:0] ev_pos_high;
    logic [31:0] ev_pos_low;
    logic [31:0] ev_rate_high;
    logic [31:0] ev_rate_low;
    logic [31:0] valve_rate;
  } valve_result_t;

  class valve_limiter_scoreboard;
    longint        lead_gain, inv_rate, power_ref, rate_open, rate_close, pos_max, pos_min;
    logic [3:0]    hold;
    valve_result_t pending[$];
    int            n_errors, n_checked;
    int            act_seen[4];

    function new();
      lead_gain = 0; inv_rate = 0; power_ref = 0; rate_open = 0;
      rate_close = 0; pos_max = 0; pos_min = 0;
      hold = '0;
      n_errors = 0; n_checked = 0;
      foreach (act_seen[i]) act_seen[i] = 0;
    endfunction

    function longint as_word(logic [31:0] w);
      int v;
      v = w;
      return longint'(v);
    endfunction

    function longint clamp(longint v);
      if (v > longint'(2147483647)) return longint'(2147483647);
      if (v < -longint'(2147483647) - 1) return -longint'(2147483647) - 1;
      return v;
    endfunction

    // floor of the Q product, saturated
    function longint q_mul(longint a, longint b);
      return clamp((a * b) >>> FRAC);
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CFG_LEAD_GAIN:  lead_gain  = as_word(val);
        CFG_INV_RATE:   inv_rate   = as_word(val);
        CFG_POWER_REF:  power_ref  = as_word(val);
        CFG_RATE_OPEN:  rate_open  = as_word(val);
        CFG_RATE_CLOSE: rate_close = as_word(val);
        CFG_POS_MAX:    pos_max    = as_word(val);
        CFG_POS_MIN:    pos_min    = as_word(val);
        default: ;
      endcase
    endfunction

    function void note_input(logic [1:0] act, logic [103:0] data);
      longint        ll, pos, dw, yll, diff, rate;
      logic [3:0]    trig, nxt;
      valve_result_t r;
      ll   = as_word(data[31:0]);
      pos  = as_word(data[63:32]);
      dw   = as_word(data[95:64]);
      trig = data[99:96];
      act_seen[act]++;
      yll  = clamp(ll + q_mul(lead_gain, dw));
      diff = clamp(power_ref - pos - yll);
      rate = q_mul(diff, inv_rate);
      r    = '0;
      nxt  = hold;
      case (act)
        ACT_EVAL: begin
          r.ev_rate_low  = 32'(hold[FL_RATE_MIN] ? clamp(rate_close - rate)
                                                 : clamp(rate - rate_close));
          r.ev_rate_high = 32'(hold[FL_RATE_MAX] ? clamp(rate - rate_open)
                                                 : clamp(rate_open - rate));
          r.ev_pos_low   = 32'(hold[FL_POS_MIN] ? clamp(-rate) : clamp(pos - pos_min));
          r.ev_pos_high  = 32'(hold[FL_POS_MAX] ? rate : clamp(pos_max - pos));
        end
        ACT_RESOLVE: begin
          nxt[FL_RATE_MIN] = hold[FL_RATE_MIN] ? !(rate > rate_open) : (rate < rate_close);
          nxt[FL_RATE_MAX] = hold[FL_RATE_MAX] ? !(rate < rate_open) : (rate > rate_open);
          nxt[FL_POS_MIN]  = hold[FL_POS_MIN]  ? !(rate > 0) : (pos < pos_min);
          nxt[FL_POS_MAX]  = hold[FL_POS_MAX]  ? !(rate < 0) : (pos > pos_max);
        end
        ACT_TRIGGER: begin
          if (trig[FL_RATE_MIN]) nxt[FL_RATE_MIN] = !hold[FL_RATE_MIN];
          if (trig[FL_RATE_MAX]) nxt[FL_RATE_MAX] = !hold[FL_RATE_MAX];
          if (trig[FL_POS_MIN])  nxt[FL_POS_MIN]  = !hold[FL_POS_MIN] && (rate < 0);
          if (trig[FL_POS_MAX])  nxt[FL_POS_MAX]  = !hold[FL_POS_MAX] && (rate > 0);
        end
        default: ;
      endcase
      hold          = nxt;
      r.valve_rate  = 32'(rate);
      r.limit_flags = hold;
      pending.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(logic [163:0] data);
      valve_result_t got, want;
      got = data;
      n_checked++;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, data);
        n_errors++;
        return;
      end
      want = pending.pop_front();
      compare("valve_rate",   want.valve_rate,   got.valve_rate);
      compare("ev_rate_low",  want.ev_rate_low,  got.ev_rate_low);
      compare("ev_rate_high", want.ev_rate_high, got.ev_rate_high);
      compare("ev_pos_low",   want.ev_pos_low,   got.ev_pos_low);
      compare("ev_pos_high",  want.ev_pos_high,  got.ev_pos_high);
      compare("limit_flags",  {28'b0, want.limit_flags}, {28'b0, got.limit_flags});
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni        = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [103:0]  s_axis_tdata  = '0;
  logic [1:0]    s_axis_tuser  = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [167:0]  m_axis_tdata;
  logic          cfg_valid_i   = 1'b0;
  logic          cfg_ready_o;
  logic [2:0]    cfg_index_i   = '0;
  logic [31:0]   cfg_data_i    = '0;

  valve_limiter_scoreboard sb = new();

  int snd_idle_pct  = 25;
  int rcv_idle_pct  = 72;
  int results_seen  = 0;
  int quiet_cycles  = 0;
  int settings_used = 0;

  governor_valve_limiter_events #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // transaction monitor: results first, then inputs, then register writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata[163:0]);
        results_seen <= results_seen + 1;
      end
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tuser, s_axis_tdata);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : watchdog
    @(negedge clk_i);
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk_i);
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("governor_valve_limiter_events regression: fail");
    $finish;
  end

  // result sink, with one long hold-off to back up the pipeline
  initial begin : result_sink
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  function automatic logic [31:0] span(int lo, int hi);
    return 32'(lo + int'($urandom_range(hi - lo)));
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return $urandom();
      1: begin
        case ($urandom_range(4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'(ONE);
        endcase
      end
      default: return span(-2 * ONE, 2 * ONE);
    endcase
  endfunction

  function automatic logic [1:0] pick_action();
    int r;
    r = $urandom_range(99);
    if (r < 35) return ACT_EVAL;
    if (r < 65) return ACT_RESOLVE;
    if (r < 92) return ACT_TRIGGER;
    return ACT_UNUSED;
  endfunction

  function automatic valve_item_t make_item(logic [1:0] act, logic [31:0] ll,
                                            logic [31:0] pos, logic [31:0] dw,
                                            logic [3:0] trig);
    valve_item_t it;
    it.action       = act;
    it.ll_state     = ll;
    it.gv_position  = pos;
    it.speed_dev    = dw;
    it.trigger_bits = trig;
    return it;
  endfunction

  function automatic limiter_cfg_t make_settings(setting_kind_e kind);
    limiter_cfg_t c;
    c.lead_gain  = span(-2 * ONE, 2 * ONE);
    c.inv_rate   = span(ONE / 4, 8 * ONE);
    c.power_ref  = span(-ONE, 2 * ONE);
    c.rate_open  = span(0, 2 * ONE);
    c.rate_close = span(-2 * ONE, 0);
    c.pos_max    = span(ONE / 2, 2 * ONE);
    c.pos_min    = span(-ONE, ONE / 2);
    case (kind)
      SET_ALGEBRAIC: c.lead_gain = '0;
      SET_NO_SERVO:  c.inv_rate  = '0;
      SET_ALL_MAX:   c = {7{32'h7FFF_FFFF}};
      SET_ALL_MIN:   c = {7{32'h8000_0000}};
      SET_WIDE:      c = {$urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom()};
      default: ;
    endcase
    return c;
  endfunction

  task automatic send_item(valve_item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, it.trigger_bits, it.speed_dev, it.gv_position, it.ll_state};
    s_axis_tuser  <= it.action;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
  endtask

  task automatic put_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic apply_settings(limiter_cfg_t c);
    cfg_valid_i <= 1'b1;
    put_reg(CFG_LEAD_GAIN,  c.lead_gain);
    put_reg(CFG_INV_RATE,   c.inv_rate);
    put_reg(CFG_POWER_REF,  c.power_ref);
    put_reg(CFG_RATE_OPEN,  c.rate_open);
    put_reg(CFG_RATE_CLOSE, c.rate_close);
    put_reg(CFG_POS_MAX,    c.pos_max);
    put_reg(CFG_POS_MIN,    c.pos_min);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // quiesce: drop the input stream, wait for every result, then let
  // the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  initial begin : stimulus
    valve_item_t  it;
    valve_item_t  point;
    valve_item_t  directed[$];
    limiter_cfg_t base;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values
    send_item(make_item(ACT_EVAL,    '0, '0, '0, 4'h0));
    send_item(make_item(ACT_RESOLVE, 32'(ONE), 32'(-ONE), '0, 4'h0));
    drain();

    base = '{lead_gain: 32'(ONE / 2), inv_rate: 32'(4 * ONE), power_ref: 32'(ONE),
             rate_open: 32'(ONE / 2), rate_close: 32'(-ONE / 2),
             pos_max: 32'(ONE), pos_min: '0};
    apply_settings(base);

    directed.push_back(make_item(ACT_EVAL, '0, '0, '0, 4'h0));
    directed.push_back(make_item(ACT_EVAL, 32'h7FFF_FFFF, 32'h8000_0000,
                                 32'h7FFF_FFFF, 4'hF));
    directed.push_back(make_item(ACT_EVAL, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'h8000_0000, 4'h0));
    // rate and position fall below their lower limits
    directed.push_back(make_item(ACT_RESOLVE, 32'(3 * ONE), 32'(-ONE), '0, 4'h0));
    // held events with the rate driven to full-scale negative
    directed.push_back(make_item(ACT_EVAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, 4'h0));
    // large positive rate releases the low holds and sets the upper rate hold
    directed.push_back(make_item(ACT_RESOLVE, 32'(-3 * ONE), 32'(ONE / 2), '0, 4'h0));
    directed.push_back(make_item(ACT_RESOLVE, '0, 32'(2 * ONE), '0, 4'h0));
    directed.push_back(make_item(ACT_EVAL, '0, 32'(2 * ONE), '0, 4'h0));
    directed.push_back(make_item(ACT_TRIGGER, '0, '0, '0, 4'hF));
    directed.push_back(make_item(ACT_TRIGGER, 32'(3 * ONE), '0, '0, 4'h1));
    directed.push_back(make_item(ACT_TRIGGER, 32'(3 * ONE), '0, '0, 4'h2));
    directed.push_back(make_item(ACT_TRIGGER, 32'(3 * ONE), '0, '0, 4'h4));
    directed.push_back(make_item(ACT_TRIGGER, 32'(3 * ONE), '0, '0, 4'h8));
    directed.push_back(make_item(ACT_TRIGGER, 32'(-3 * ONE), '0, '0, 4'hC));
    directed.push_back(make_item(ACT_TRIGGER, '0, '0, '0, 4'h0));
    directed.push_back(make_item(ACT_UNUSED, 32'(ONE), '0, '0, 4'hF));
    directed.push_back(make_item(ACT_EVAL, '0, '0, 32'h7FFF_FFFF, 4'h0));
    directed.push_back(make_item(ACT_RESOLVE, '0, '0, 32'h8000_0000, 4'h0));
    directed.push_back(make_item(ACT_EVAL, 32'hFFFF_FFFF, 32'h0000_0001,
                                 32'hFFFF_FFFF, 4'h0));
    foreach (directed[i]) send_item(directed[i]);
    drain();

    point = make_item(ACT_EVAL, pick_value(), pick_value(), pick_value(), 4'h0);
    foreach (PHASE_PLAN[p]) begin
      if (p < 3) begin
        snd_idle_pct = 25;
        rcv_idle_pct = 72;
      end else if (p < 6) begin
        snd_idle_pct = 72;
        rcv_idle_pct = 25;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      apply_settings(make_settings(PHASE_PLAN[p]));
      repeat (PHASE_ITEMS) begin
        // mostly repeated calls at one operating point, as a solver does
        if ($urandom_range(99) < 35) begin
          point.ll_state    = pick_value();
          point.gv_position = pick_value();
          point.speed_dev   = pick_value();
        end
        it = make_item(pick_action(), point.ll_state, point.gv_position,
                       point.speed_dev, 4'($urandom_range(15)));
        send_item(it);
      end
      drain();
    end

    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
      sb.n_errors++;
    end
    $display("Checked %0d results over %0d register settings: %0d eval, %0d resolve,",
             sb.n_checked, settings_used, sb.act_seen[ACT_EVAL], sb.act_seen[ACT_RESOLVE]);
    $display("%0d trigger, %0d unused-action items; one %0d-cycle output back-pressure.",
             sb.act_seen[ACT_TRIGGER], sb.act_seen[ACT_UNUSED], HOLD_LEN);
    if (sb.n_errors == 0) begin
      $display("governor_valve_limiter_events regression: pass");
    end else begin
      $display("governor_valve_limiter_events regression: fail");
    end
    $finish;
  end

endmodule
